/* rtl/dds_pkg.sv */
// Shared types and codes for the drink dispense sequencer.
`timescale 1ns / 1ps
`default_nettype none

package dds_pkg;

  // Phase codes
  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_CHOOSE  = 2'd1;
  localparam logic [1:0] PH_SERVE   = 2'd2;
  localparam logic [1:0] PH_COLLECT = 2'd3;

  // Message codes
  localparam logic [2:0] MSG_NONE    = 3'd0;
  localparam logic [2:0] MSG_WAIT    = 3'd1;
  localparam logic [2:0] MSG_SELECT  = 3'd2;
  localparam logic [2:0] MSG_BLACK   = 3'd3;
  localparam logic [2:0] MSG_MILK    = 3'd4;
  localparam logic [2:0] MSG_COLLECT = 3'd5;

  // Configuration register indexes
  localparam logic [2:0] REG_PRESCALE_MS    = 3'd0;
  localparam logic [2:0] REG_BLINK_PERIOD   = 3'd1;
  localparam logic [2:0] REG_SELECT_TIMEOUT = 3'd2;
  localparam logic [2:0] REG_BREW_TIME      = 3'd3;
  localparam logic [2:0] REG_MILK_SWITCH    = 3'd4;
  localparam logic [2:0] REG_COLLECT_TIME   = 3'd5;

  // Configuration reset values
  localparam logic [7:0] RST_PRESCALE_MS    = 8'd100;
  localparam logic [7:0] RST_BLINK_PERIOD   = 8'd5;
  localparam logic [7:0] RST_SELECT_TIMEOUT = 8'd50;
  localparam logic [7:0] RST_BREW_TIME      = 8'd80;
  localparam logic [7:0] RST_MILK_SWITCH    = 8'd40;
  localparam logic [7:0] RST_COLLECT_TIME   = 8'd20;

  localparam logic [7:0] COUNT_MAX = 8'hFF;

  typedef struct packed {
    logic [7:0] prescale_ms;
    logic [7:0] blink_period;
    logic [7:0] select_timeout;
    logic [7:0] brew_time;
    logic [7:0] milk_switch;
    logic [7:0] collect_time;
  } cfg_t;

  typedef struct packed {
    logic [1:0] phase;
    logic [7:0] ms_count;
    logic [7:0] slow_count;
    logic       drink_is_milk;
    logic       lamp;
    logic       coffee_on;
    logic       milk_on;
    logic       buzz_on;
  } state_t;

  typedef struct packed {
    logic ms_tick;
    logic coin;
    logic want_black;
    logic want_milk;
  } step_in_t;

endpackage

`default_nettype wire

/* rtl/dds_cfg.sv */
// Configuration register file of the drink dispense sequencer.
`timescale 1ns / 1ps
`default_nettype none

module dds_cfg (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         wr_en,
  input  wire logic [2:0]   wr_index,
  input  wire logic [7:0]   wr_data,
  output dds_pkg::cfg_t     cfg
);

  // Write one register per transaction; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.prescale_ms    <= dds_pkg::RST_PRESCALE_MS;
      cfg.blink_period   <= dds_pkg::RST_BLINK_PERIOD;
      cfg.select_timeout <= dds_pkg::RST_SELECT_TIMEOUT;
      cfg.brew_time      <= dds_pkg::RST_BREW_TIME;
      cfg.milk_switch    <= dds_pkg::RST_MILK_SWITCH;
      cfg.collect_time   <= dds_pkg::RST_COLLECT_TIME;
    end else if (wr_en) begin
      unique case (wr_index)
        dds_pkg::REG_PRESCALE_MS:    cfg.prescale_ms    <= wr_data;
        dds_pkg::REG_BLINK_PERIOD:   cfg.blink_period   <= wr_data;
        dds_pkg::REG_SELECT_TIMEOUT: cfg.select_timeout <= wr_data;
        dds_pkg::REG_BREW_TIME:      cfg.brew_time      <= wr_data;
        dds_pkg::REG_MILK_SWITCH:    cfg.milk_switch    <= wr_data;
        dds_pkg::REG_COLLECT_TIME:   cfg.collect_time   <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/dds_step.sv */
// Next-state and message logic for one step of the sequencer.
`timescale 1ns / 1ps
`default_nettype none

module dds_step (
  input  wire dds_pkg::cfg_t     cfg,
  input  wire dds_pkg::state_t   cur,
  input  wire dds_pkg::step_in_t din,
  output dds_pkg::state_t  nxt,
  output logic [2:0]       message
);

  logic [8:0] ms_inc;
  logic       slow;
  logic [7:0] slow_sat;

  // Prescale millisecond ticks into slow ticks
  assign ms_inc   = {1'b0, cur.ms_count} + 9'd1;
  assign slow_sat = (cur.slow_count == dds_pkg::COUNT_MAX) ? cur.slow_count
                                                           : cur.slow_count + 8'd1;

  always_comb begin
    nxt     = cur;
    message = dds_pkg::MSG_NONE;
    slow    = 1'b0;

    if (din.ms_tick) begin
      if (ms_inc >= {1'b0, cfg.prescale_ms}) begin
        nxt.ms_count = '0;
        slow         = 1'b1;
      end else begin
        nxt.ms_count = ms_inc[7:0];
      end
    end

    // Advance the phase machine
    unique case (cur.phase)
      dds_pkg::PH_IDLE: begin
        if (din.coin) begin
          nxt.phase      = dds_pkg::PH_CHOOSE;
          message        = dds_pkg::MSG_SELECT;
          nxt.slow_count = '0;
          nxt.lamp       = 1'b1;
        end else if (slow) begin
          if (cur.slow_count < cfg.blink_period) begin
            nxt.slow_count = slow_sat;
          end else begin
            nxt.lamp       = ~cur.lamp;
            nxt.slow_count = '0;
          end
        end
      end
      dds_pkg::PH_CHOOSE: begin
        if (din.want_black || din.want_milk) begin
          nxt.phase         = dds_pkg::PH_SERVE;
          nxt.drink_is_milk = ~din.want_black;
          message           = din.want_black ? dds_pkg::MSG_BLACK : dds_pkg::MSG_MILK;
          nxt.coffee_on     = 1'b1;
          nxt.slow_count    = '0;
        end else if (slow) begin
          if (cur.slow_count >= cfg.select_timeout) begin
            nxt.slow_count = '0;
            nxt.lamp       = 1'b0;
            nxt.phase      = dds_pkg::PH_IDLE;
          end else begin
            nxt.slow_count = slow_sat;
          end
        end
      end
      dds_pkg::PH_SERVE: begin
        if (slow) begin
          // Milk swap wins over every other serve action
          if (cur.drink_is_milk && (cur.slow_count == cfg.milk_switch)) begin
            nxt.coffee_on  = 1'b0;
            nxt.milk_on    = 1'b1;
            nxt.lamp       = ~cur.lamp;
            nxt.slow_count = slow_sat;
          end else if (cur.slow_count < cfg.brew_time) begin
            nxt.lamp       = ~cur.lamp;
            nxt.slow_count = slow_sat;
          end else begin
            nxt.coffee_on  = 1'b0;
            nxt.milk_on    = 1'b0;
            nxt.slow_count = '0;
            nxt.phase      = dds_pkg::PH_COLLECT;
            message        = dds_pkg::MSG_COLLECT;
            nxt.buzz_on    = 1'b1;
            nxt.lamp       = 1'b0;
          end
        end
      end
      default: begin
        if (slow) begin
          if (cur.slow_count >= cfg.collect_time) begin
            nxt.slow_count = '0;
            nxt.buzz_on    = 1'b0;
            nxt.lamp       = 1'b1;
            nxt.phase      = dds_pkg::PH_IDLE;
            message        = dds_pkg::MSG_WAIT;
          end else begin
            nxt.slow_count = slow_sat;
          end
        end
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/drink_dispense_sequencer_top.sv */
// Top level of the drink dispense sequencer: stream stages, state and checks.
//
//  channel | direction | handshake        | payload
//  --------+-----------+------------------+-----------------------------------
//  s_*     | in        | s_tvalid/tready  | s_tdata: one step of request flags
//  m_*     | out       | m_tvalid/tready  | m_tdata: phase, outputs, message
//  cfg_*   | in        | cfg_valid/ready  | cfg_index, cfg_data
//
// One step per cycle sustained while results are taken; a step passes the input register,
// then goes through the step logic into the result register.
// Reset (rst, synchronous) restores the register defaults and the idle state.
// A stalled result holds the result register; the input register still takes a
// step when the result is taken in the same cycle. Config is always ready.
`timescale 1ns / 1ps
`default_nettype none

module drink_dispense_sequencer_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [0] ms_tick [1] coin [2] want_black [3] want_milk
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [1:0] phase [2] indicator [3] coffee_valve
                                      // [4] milk_valve [5] buzzer [8:6] message
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  dds_pkg::cfg_t     cfg;
  dds_pkg::state_t   state;
  dds_pkg::state_t   state_next;
  dds_pkg::step_in_t in_reg;
  logic              in_valid;
  logic [2:0]        message_next;
  logic              advance;

  assign cfg_ready = 1'b1;

  dds_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  dds_step u_step (
    .cfg     (cfg),
    .cur     (state),
    .din     (in_reg),
    .nxt     (state_next),
    .message (message_next)
  );

  // Move a step into the result register when it is free or being taken
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_reg.ms_tick    <= s_tdata[0];
      in_reg.coin       <= s_tdata[1];
      in_reg.want_black <= s_tdata[2];
      in_reg.want_milk  <= s_tdata[3];
    end
  end

  // Sequencer state, updated once per step
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase         <= dds_pkg::PH_IDLE;
      state.ms_count      <= '0;
      state.slow_count    <= '0;
      state.drink_is_milk <= 1'b0;
      state.lamp          <= 1'b0;
      state.coffee_on     <= 1'b0;
      state.milk_on       <= 1'b0;
      state.buzz_on       <= 1'b0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {7'd0, message_next, state_next.buzz_on, state_next.milk_on,
                  state_next.coffee_on, state_next.lamp, state_next.phase};
    end
  end

  // Valves are exclusive
  a_valves_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(state.coffee_on && state.milk_on))
    else $error("coffee and milk valves open together");

  // Valves open only while serving
  a_valves_in_serve: assert property (@(posedge clk) disable iff (rst)
    (state.coffee_on || state.milk_on) |-> (state.phase == dds_pkg::PH_SERVE))
    else $error("valve open outside serve");

  // Buzzer sounds only in collect
  a_buzz_in_collect: assert property (@(posedge clk) disable iff (rst)
    state.buzz_on |-> (state.phase == dds_pkg::PH_COLLECT))
    else $error("buzzer on outside collect");

  // Prescaler never reaches its wrap value
  a_ms_below_max: assert property (@(posedge clk) disable iff (rst)
    state.ms_count != dds_pkg::COUNT_MAX)
    else $error("millisecond count at its maximum");

  // State moves only when a step is passed to the result register
  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(state))
    else $error("state changed without a step");

endmodule

`default_nettype wire

/* verif/dds_result_checker.sv */
// Result checker for the drink dispense sequencer: mirrors the machine and compares every result.
`timescale 1ns / 1ps

module dds_result_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [7:0]  s_tdata,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [15:0] m_tdata,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  output int               fault_count,
  output int               outstanding,
  output int               results_seen
);
  import dds_pkg::*;

  typedef struct packed {
    logic [1:0] phase;
    logic       indicator;
    logic       coffee_valve;
    logic       milk_valve;
    logic       buzzer;
    logic [2:0] message;
  } panel_t;

  cfg_t   regs;
  state_t st;
  panel_t due_panels[$];
  panel_t want;
  panel_t got;
  int     faults;
  int     seen;
  logic   bad;

  initial begin
    fault_count  = 0;
    outstanding  = 0;
    results_seen = 0;
    faults       = 0;
    seen         = 0;
  end

  // Advance the slow counter, saturating at full scale.
  function automatic void bump_slow();
    if (st.slow_count != COUNT_MAX) st.slow_count = st.slow_count + 8'd1;
  endfunction

  // Apply one step to the mirrored machine and return the panel it shows afterwards.
  function automatic panel_t dispense_step(input logic [3:0] req);
    logic       ms;
    logic       coin;
    logic       black;
    logic       milk;
    logic       slow;
    logic [8:0] ms_next;
    panel_t     res;
    ms          = req[0];
    coin        = req[1];
    black       = req[2];
    milk        = req[3];
    slow        = 1'b0;
    res.message = MSG_NONE;

    // Prescaler acts first; its slow tick is seen by the phase logic in the same step.
    if (ms) begin
      ms_next = {1'b0, st.ms_count} + 9'd1;
      if (ms_next >= {1'b0, regs.prescale_ms}) begin
        st.ms_count = 8'd0;
        slow        = 1'b1;
      end else begin
        st.ms_count = ms_next[7:0];
      end
    end

    case (st.phase)
      PH_IDLE: begin
        if (coin) begin
          st.phase      = PH_CHOOSE;
          res.message   = MSG_SELECT;
          st.slow_count = 8'd0;
          st.lamp       = 1'b1;
        end else if (slow) begin
          if (st.slow_count < regs.blink_period) begin
            bump_slow();
          end else begin
            st.lamp       = ~st.lamp;
            st.slow_count = 8'd0;
          end
        end
      end
      PH_CHOOSE: begin
        // Black wins when both buttons are pressed.
        if (black || milk) begin
          st.phase         = PH_SERVE;
          st.drink_is_milk = ~black;
          res.message      = black ? MSG_BLACK : MSG_MILK;
          st.coffee_on     = 1'b1;
          st.slow_count    = 8'd0;
        end else if (slow) begin
          if (st.slow_count >= regs.select_timeout) begin
            st.slow_count = 8'd0;
            st.lamp       = 1'b0;
            st.phase      = PH_IDLE;
          end else begin
            bump_slow();
          end
        end
      end
      PH_SERVE: begin
        if (slow) begin
          // The milk swap outranks the end-of-brew check.
          if (st.drink_is_milk && st.slow_count == regs.milk_switch) begin
            st.coffee_on = 1'b0;
            st.milk_on   = 1'b1;
            st.lamp      = ~st.lamp;
            bump_slow();
          end else if (st.slow_count < regs.brew_time) begin
            st.lamp = ~st.lamp;
            bump_slow();
          end else begin
            st.coffee_on  = 1'b0;
            st.milk_on    = 1'b0;
            st.slow_count = 8'd0;
            st.phase      = PH_COLLECT;
            res.message   = MSG_COLLECT;
            st.buzz_on    = 1'b1;
            st.lamp       = 1'b0;
          end
        end
      end
      default: begin
        if (slow) begin
          if (st.slow_count >= regs.collect_time) begin
            st.slow_count = 8'd0;
            st.buzz_on    = 1'b0;
            st.lamp       = 1'b1;
            st.phase      = PH_IDLE;
            res.message   = MSG_WAIT;
          end else begin
            bump_slow();
          end
        end
      end
    endcase

    res.phase        = st.phase;
    res.indicator    = st.lamp;
    res.coffee_valve = st.coffee_on;
    res.milk_valve   = st.milk_on;
    res.buzzer       = st.buzz_on;
    return res;
  endfunction

  // Watch all three channels at each edge; outputs move by NBA so readers see settled values.
  always @(posedge clk) begin
    if (rst) begin
      regs.prescale_ms    = RST_PRESCALE_MS;
      regs.blink_period   = RST_BLINK_PERIOD;
      regs.select_timeout = RST_SELECT_TIMEOUT;
      regs.brew_time      = RST_BREW_TIME;
      regs.milk_switch    = RST_MILK_SWITCH;
      regs.collect_time   = RST_COLLECT_TIME;
      st                  = '0;
      st.phase            = PH_IDLE;
      due_panels.delete();
    end else begin
      // Mirror register writes.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PRESCALE_MS:    regs.prescale_ms    = cfg_data;
          REG_BLINK_PERIOD:   regs.blink_period   = cfg_data;
          REG_SELECT_TIMEOUT: regs.select_timeout = cfg_data;
          REG_BREW_TIME:      regs.brew_time      = cfg_data;
          REG_MILK_SWITCH:    regs.milk_switch    = cfg_data;
          REG_COLLECT_TIME:   regs.collect_time   = cfg_data;
          default: ;
        endcase
      end

      // Compare each result transaction with the oldest prediction.
      if (m_tvalid && m_tready) begin
        seen++;
        got.phase        = m_tdata[1:0];
        got.indicator    = m_tdata[2];
        got.coffee_valve = m_tdata[3];
        got.milk_valve   = m_tdata[4];
        got.buzzer       = m_tdata[5];
        got.message      = m_tdata[8:6];
        if (due_panels.size() == 0) begin
          faults++;
          if (faults <= 10)
            $display("result %0d arrived with no step waiting: data=%h", seen, m_tdata);
        end else begin
          want = due_panels.pop_front();
          bad  = (got.phase !== want.phase) || (got.indicator !== want.indicator) ||
                 (got.coffee_valve !== want.coffee_valve) ||
                 (got.milk_valve !== want.milk_valve) ||
                 (got.buzzer !== want.buzzer) || (got.message !== want.message);
          if (bad) begin
            faults++;
            if (faults <= 10) begin
              $display("result %0d mismatch: want ph=%0d ind=%b cof=%b mlk=%b buz=%b msg=%0d",
                       seen, want.phase, want.indicator, want.coffee_valve,
                       want.milk_valve, want.buzzer, want.message);
              $display("                     got  ph=%0d ind=%b cof=%b mlk=%b buz=%b msg=%0d",
                       got.phase, got.indicator, got.coffee_valve,
                       got.milk_valve, got.buzzer, got.message);
            end
          end
        end
      end

      // Predict the result of each accepted step.
      if (s_tvalid && s_tready) due_panels.push_back(dispense_step(s_tdata[3:0]));
    end

    outstanding  <= due_panels.size();
    fault_count  <= faults;
    results_seen <= seen;
  end

endmodule

/* verif/drink_dispense_sequencer_top_tb.sv */
// Testbench top for the drink dispense sequencer: stimulus, idling, watchdog and verdict.
`timescale 1ns / 1ps

module drink_dispense_sequencer_top_tb;
  import dds_pkg::*;

  // Request flag bits of one step
  localparam logic [3:0] REQ_MS    = 4'b0001;
  localparam logic [3:0] REQ_COIN  = 4'b0010;
  localparam logic [3:0] REQ_BLACK = 4'b0100;
  localparam logic [3:0] REQ_MILK  = 4'b1000;
  localparam logic [3:0] REQ_NONE  = 4'b0000;

  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 60;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata   = 8'd0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [15:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = REG_PRESCALE_MS;
  logic [7:0]  cfg_data  = 8'd0;

  int fault_count;
  int outstanding;
  int results_seen;

  int src_idle_pct  = 0;
  int sink_idle_pct = 0;
  int hold_asks     = 0;
  int holds_done    = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;
  int steps_sent    = 0;
  int settings_used = 0;

  drink_dispense_sequencer_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  dds_result_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fault_count  (fault_count),
    .outstanding  (outstanding),
    .results_seen (results_seen)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Drive output ready: long holds on request, random stalls otherwise.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready  <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_asks != holds_done) begin
      holds_done <= holds_done + 1;
      hold_left  <= HOLD_CYCLES;
      m_tready   <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // End the run when no transaction moves for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
      $display("drink_dispense_sequencer_top_tb: done, errors");
      $finish;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Write all six registers back to back.
  task automatic load_setting(input cfg_t c);
    write_reg(REG_PRESCALE_MS, c.prescale_ms);
    write_reg(REG_BLINK_PERIOD, c.blink_period);
    write_reg(REG_SELECT_TIMEOUT, c.select_timeout);
    write_reg(REG_BREW_TIME, c.brew_time);
    write_reg(REG_MILK_SWITCH, c.milk_switch);
    write_reg(REG_COLLECT_TIME, c.collect_time);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // Offer one step, with an optional idle gap ahead of it.
  task automatic send_step(input logic [3:0] req);
    int gap;
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      gap = $urandom_range(3, 1);
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0000, req};
    do @(posedge clk); while (!s_tready);
    steps_sent++;
  endtask

  // Drop valid and wait until every predicted result has been taken.
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Mostly plausible human input, with some fully random noise.
  function automatic logic [3:0] random_request(input int ms_pct);
    logic [3:0] r;
    if ($urandom_range(99) < 12) return 4'($urandom_range(15));
    r[0] = ($urandom_range(99) < ms_pct);
    r[1] = ($urandom_range(99) < 8);
    r[2] = ($urandom_range(99) < 6);
    r[3] = ($urandom_range(99) < 6);
    return r;
  endfunction

  // One register setting followed by a burst of random steps.
  task automatic run_phase(input cfg_t c, input int count, input int ms_pct,
                           input logic lead_milk);
    load_setting(c);
    if (lead_milk) begin
      send_step(REQ_COIN | REQ_MS);
      send_step(REQ_MILK | REQ_MS);
    end
    repeat (count) send_step(random_request(ms_pct));
    drain();
  endtask

  initial begin
    cfg_t low_cfg;
    cfg_t setting;

    low_cfg = '{8'd0, 8'd0, 8'd0, 8'd1, 8'd0, 8'd0};

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: register defaults; ignored buttons and coin, both buttons pick black.
    src_idle_pct  = 7;
    sink_idle_pct = 45;
    send_step(REQ_NONE);
    send_step(REQ_MILK | REQ_BLACK);
    send_step(REQ_MS | REQ_COIN);
    send_step(REQ_COIN | REQ_MS);
    send_step(REQ_BLACK | REQ_MILK);
    send_step(REQ_COIN | REQ_BLACK | REQ_MILK | REQ_MS);
    drain();

    // Directed: zero prescale, brew time of one, other limits zero; finish brew, blink, timeout, milk swap.
    load_setting(low_cfg);
    send_step(REQ_MS);
    send_step(REQ_MS);
    send_step(REQ_MS | REQ_BLACK);
    send_step(REQ_MS);
    send_step(REQ_MS);
    send_step(REQ_COIN);
    send_step(REQ_MS);
    send_step(REQ_COIN | REQ_MS);
    send_step(REQ_MILK | REQ_MS | REQ_COIN);
    send_step(REQ_MS);
    send_step(REQ_MS);
    send_step(REQ_NONE);
    send_step(REQ_MS | REQ_MILK);
    send_step(REQ_BLACK | REQ_COIN);
    send_step(REQ_MILK | REQ_BLACK | REQ_COIN | REQ_MS);
    drain();

    // Short limits, with one long output hold that backs up the input.
    hold_asks++;
    setting = '{8'd1, 8'd2, 8'd3, 8'd6, 8'd3, 8'd2};
    run_phase(setting, 180, 80, 1'b0);
    setting = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
    run_phase(setting, 80, 60, 1'b0);

    // Swap idling: sender sparse, receiver mostly ready.
    src_idle_pct  = 45;
    sink_idle_pct = 7;
    setting.prescale_ms    = 8'd3;
    setting.blink_period   = 8'($urandom_range(8));
    setting.select_timeout = 8'($urandom_range(8));
    setting.brew_time      = 8'($urandom_range(8));
    setting.milk_switch    = 8'($urandom_range(8));
    setting.collect_time   = 8'($urandom_range(8));
    run_phase(setting, 140, 85, 1'b0);
    setting = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255};
    run_phase(setting, 80, 90, 1'b0);

    // No idling from here. Bring the machine back to idle quickly.
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    load_setting(low_cfg);
    repeat (6) send_step(REQ_MS);
    drain();

    // Full-scale limits with a milk drink: slow count saturates at the swap point.
    setting = '{8'd1, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255};
    run_phase(setting, 340, 97, 1'b1);

    // Lower the limits under the saturated counter, with another long hold.
    hold_asks++;
    setting = '{8'd2, 8'd2, 8'd4, 8'd20, 8'd10, 8'd3};
    run_phase(setting, 80, 85, 1'b0);

    setting.prescale_ms    = 8'($urandom_range(2));
    setting.blink_period   = 8'($urandom_range(6));
    setting.select_timeout = 8'($urandom_range(6));
    setting.brew_time      = 8'($urandom_range(6));
    setting.milk_switch    = 8'($urandom_range(6));
    setting.collect_time   = 8'($urandom_range(6));
    run_phase(setting, 80, 80, 1'b0);

    // Let any stray result show up before the verdict.
    repeat (6) @(posedge clk);

    $display("covered %0d steps under %0d register settings, %0d results compared",
             steps_sent, settings_used, results_seen);
    $display("included zero and full-scale limits, long output holds and both idling mixes");
    if (fault_count == 0 && outstanding == 0) begin
      $display("drink_dispense_sequencer_top_tb: done, clean");
    end else begin
      $display("%0d failures, %0d results still expected", fault_count, outstanding);
      $display("drink_dispense_sequencer_top_tb: done, errors");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/dds_pkg.sv
rtl/dds_cfg.sv
rtl/dds_step.sv
rtl/drink_dispense_sequencer_top.sv
verif/dds_result_checker.sv
verif/drink_dispense_sequencer_top_tb.sv
